@@ sv/spg_pkg.sv @@
// ----------------------------------------------------------------------------
// spg_pkg
// shared types, constants and helper functions of the permutation generator
// ----------------------------------------------------------------------------
package spg_pkg;

  localparam int MAX_ELEMS  = 9;
  localparam int IDX_W      = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int ELEM_W     = 4;
  localparam int ORDER_W    = 36;
  localparam int OUT_POS    = ORDER_W / ELEM_W;
  localparam int SHOW_POS   = (MAX_ELEMS < OUT_POS) ? MAX_ELEMS : OUT_POS;
  localparam int SEQ_W      = 19;
  localparam int COUNT_W    = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(9);

  // register index codes, taken from paddr[2]
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  typedef logic [MAX_ELEMS-1:0][IDX_W-1:0] idx_vec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UNWIND,
    ST_ADVANCE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic               count_wr;
    logic [COUNT_W-1:0] count;
  } cfg_ctl_t;

  function automatic idx_vec_t identity_vec();
    idx_vec_t v;
    for (int k = 0; k < MAX_ELEMS; k++) begin
      v[k] = IDX_W'(k);
    end
    return v;
  endfunction

  function automatic logic [COUNT_W-1:0] eff_count(logic [COUNT_W-1:0] raw);
    logic [COUNT_W-1:0] n;
    n = raw;
    if (n == '0) n = COUNT_W'(1);
    if (n > COUNT_W'(MAX_ELEMS)) n = COUNT_W'(MAX_ELEMS);
    return n;
  endfunction

  function automatic logic [ORDER_W-1:0] pack_order(idx_vec_t v, logic [COUNT_W-1:0] n);
    logic [ORDER_W-1:0] w;
    w = '0;
    for (int k = 0; k < SHOW_POS; k++) begin
      if (COUNT_W'(k) < n) w[ELEM_W*k +: ELEM_W] = ELEM_W'(v[k]);
    end
    return w;
  endfunction

  function automatic logic at_final(idx_vec_t c, logic [COUNT_W-1:0] n);
    logic fin;
    fin = 1'b1;
    for (int k = 0; k < MAX_ELEMS; k++) begin
      if ((COUNT_W'(k + 1) < n) && (c[k] != IDX_W'(n - COUNT_W'(1)))) fin = 1'b0;
    end
    return fin;
  endfunction

endpackage

@@ sv/spg_ifs.sv @@
// ----------------------------------------------------------------------------
// spg channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface spg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface spg_out_if;
  logic                          valid;
  logic                          ready;
  logic [spg_pkg::ORDER_W-1:0]   order_word;
  logic [spg_pkg::SEQ_W-1:0]     sequence_number;
  logic                          is_last;
  logic                          exhausted;

  modport source (output valid, output order_word, output sequence_number,
                  output is_last, output exhausted, input ready);
  modport sink   (input valid, input order_word, input sequence_number,
                  input is_last, input exhausted, output ready);
endinterface

@@ sv/spg_swap_unit.sv @@
// ----------------------------------------------------------------------------
// spg_swap_unit
// shared exchange of two positions of the order store
// ----------------------------------------------------------------------------
module spg_swap_unit (
  input  spg_pkg::idx_vec_t           vec_in,
  input  logic [spg_pkg::IDX_W-1:0]   pos_a,
  input  logic [spg_pkg::IDX_W-1:0]   pos_b,
  output spg_pkg::idx_vec_t           vec_out
);

  logic [spg_pkg::IDX_W-1:0] val_a;
  logic [spg_pkg::IDX_W-1:0] val_b;

  assign val_a = vec_in[pos_a];
  assign val_b = vec_in[pos_b];

  always_comb begin
    vec_out = vec_in;
    for (int k = 0; k < spg_pkg::MAX_ELEMS; k++) begin
      if (pos_a == spg_pkg::IDX_W'(k)) begin
        vec_out[k] = val_b;
      end else if (pos_b == spg_pkg::IDX_W'(k)) begin
        vec_out[k] = val_a;
      end
    end
  end

endmodule

@@ sv/spg_apb_regs.sv @@
// ----------------------------------------------------------------------------
// spg_apb_regs
// apb register slave holding the element count
// ----------------------------------------------------------------------------
module spg_apb_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [spg_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [spg_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [spg_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output spg_pkg::cfg_ctl_t                 ctl
);

  logic [spg_pkg::COUNT_W-1:0] count_r;
  logic [spg_pkg::COUNT_W-1:0] count_nxt;
  logic                        wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready &&
                  (paddr[2] == spg_pkg::REG_ELEMENT_COUNT);

  assign count_nxt = wr_hit ? pwdata[spg_pkg::COUNT_W-1:0] : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= spg_pkg::COUNT_RESET;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == spg_pkg::REG_ELEMENT_COUNT) begin
      prdata = spg_pkg::CFG_DATA_W'(count_r);
    end
  end

  assign ctl.count_wr = wr_hit;
  assign ctl.count    = count_r;

endmodule

@@ sv/swap_recursive_permutation_generator_top.sv @@
// ----------------------------------------------------------------------------
// swap_recursive_permutation_generator_top
// next permutation in recursive swap-and-restore order, one per request
// ----------------------------------------------------------------------------
// Each request returns one result. A restart request, or a request that finds
// no enumeration running or only one element, goes from idle straight to the
// result state. A next request that steps to a new permutation unwinds L
// recursion levels, with L from 1 to element_count - 1: the sequencer walks
// the levels one per cycle through a single shared swap unit, then makes one
// more swap to step the chosen level. The request that runs past the final
// permutation unwinds every level and returns exhausted. The request channel
// is ready only while the sequencer is idle, and a new result that finds the
// output register still full holds the sequencer until that register is
// taken.
// A register write to element_count stops the running enumeration.
module swap_recursive_permutation_generator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  spg_in_if.sink                            in_ch,
  spg_out_if.source                         out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [spg_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [spg_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [spg_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  spg_pkg::cfg_ctl_t cfg_ctl;

  spg_pkg::state_t              state_r, state_nxt;
  logic [spg_pkg::IDX_W-1:0]    lvl_r, lvl_nxt;
  spg_pkg::idx_vec_t            order_r, order_nxt;
  spg_pkg::idx_vec_t            choice_r, choice_nxt;
  logic [spg_pkg::SEQ_W-1:0]    seq_r, seq_nxt;
  logic                         running_r, running_nxt;
  logic                         good_r, good_nxt;

  logic                         out_valid_r;
  logic [spg_pkg::ORDER_W-1:0]  out_word_r;
  logic [spg_pkg::SEQ_W-1:0]    out_seq_r;
  logic                         out_last_r;
  logic                         out_exh_r;
  logic                         out_load;

  logic [spg_pkg::COUNT_W-1:0]  n_eff;
  logic [spg_pkg::IDX_W-1:0]    n_top;
  logic [spg_pkg::IDX_W-1:0]    cur_choice;
  spg_pkg::idx_vec_t            swapped;

  spg_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .ctl     (cfg_ctl)
  );

  assign n_eff      = spg_pkg::eff_count(cfg_ctl.count);
  assign n_top      = spg_pkg::IDX_W'(n_eff - spg_pkg::COUNT_W'(1));
  assign cur_choice = choice_r[lvl_r];

  spg_swap_unit u_swap (
    .vec_in  (order_r),
    .pos_a   (lvl_r),
    .pos_b   (cur_choice),
    .vec_out (swapped)
  );

  assign in_ch.ready = (state_r == spg_pkg::ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    lvl_nxt     = lvl_r;
    order_nxt   = order_r;
    choice_nxt  = choice_r;
    seq_nxt     = seq_r;
    running_nxt = running_r;
    good_nxt    = good_r;
    out_load    = 1'b0;
    case (state_r)
      spg_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.restart) begin
            order_nxt   = spg_pkg::identity_vec();
            choice_nxt  = spg_pkg::identity_vec();
            seq_nxt     = spg_pkg::SEQ_W'(1);
            running_nxt = 1'b1;
            good_nxt    = 1'b1;
            state_nxt   = spg_pkg::ST_RESULT;
          end else if (running_r && (n_eff >= spg_pkg::COUNT_W'(2))) begin
            lvl_nxt   = spg_pkg::IDX_W'(n_eff - spg_pkg::COUNT_W'(2));
            state_nxt = spg_pkg::ST_UNWIND;
          end else if (running_r) begin
            // single element: nothing follows the identity
            order_nxt   = spg_pkg::identity_vec();
            choice_nxt  = spg_pkg::identity_vec();
            seq_nxt     = '0;
            running_nxt = 1'b0;
            good_nxt    = 1'b0;
            state_nxt   = spg_pkg::ST_RESULT;
          end else begin
            good_nxt  = 1'b0;
            state_nxt = spg_pkg::ST_RESULT;
          end
        end
      end
      spg_pkg::ST_UNWIND: begin
        order_nxt = swapped;
        if (cur_choice < n_top) begin
          choice_nxt[lvl_r] = cur_choice + spg_pkg::IDX_W'(1);
          state_nxt         = spg_pkg::ST_ADVANCE;
        end else if (lvl_r == '0) begin
          // enumeration complete
          order_nxt   = spg_pkg::identity_vec();
          choice_nxt  = spg_pkg::identity_vec();
          seq_nxt     = '0;
          running_nxt = 1'b0;
          good_nxt    = 1'b0;
          state_nxt   = spg_pkg::ST_RESULT;
        end else begin
          lvl_nxt = lvl_r - spg_pkg::IDX_W'(1);
        end
      end
      spg_pkg::ST_ADVANCE: begin
        order_nxt = swapped;
        for (int k = 0; k < spg_pkg::MAX_ELEMS; k++) begin
          if (spg_pkg::IDX_W'(k) > lvl_r) choice_nxt[k] = spg_pkg::IDX_W'(k);
        end
        seq_nxt   = seq_r + spg_pkg::SEQ_W'(1);
        good_nxt  = 1'b1;
        state_nxt = spg_pkg::ST_RESULT;
      end
      spg_pkg::ST_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = spg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spg_pkg::ST_IDLE;
      end
    endcase
    if (cfg_ctl.count_wr) begin
      running_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= spg_pkg::ST_IDLE;
      lvl_r     <= '0;
      order_r   <= spg_pkg::identity_vec();
      choice_r  <= spg_pkg::identity_vec();
      seq_r     <= '0;
      running_r <= 1'b0;
      good_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      lvl_r     <= lvl_nxt;
      order_r   <= order_nxt;
      choice_r  <= choice_nxt;
      seq_r     <= seq_nxt;
      running_r <= running_nxt;
      good_r    <= good_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= good_r ? spg_pkg::pack_order(order_r, n_eff) : '0;
      out_seq_r  <= good_r ? seq_r : '0;
      out_last_r <= good_r && spg_pkg::at_final(choice_r, n_eff);
      out_exh_r  <= !good_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.order_word      = out_word_r;
  assign out_ch.sequence_number = out_seq_r;
  assign out_ch.is_last         = out_last_r;
  assign out_ch.exhausted       = out_exh_r;

  // exhausted result carries no permutation
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_exh_r |-> (out_word_r == '0) && (out_seq_r == '0) && !out_last_r)
    else $error("exhausted request carries payload");

  // a delivered permutation always has a nonzero sequence number
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_exh_r |-> (out_seq_r != '0))
    else $error("permutation with zero sequence number");

  // a count write stops the enumeration
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ctl.count_wr |=> !running_r)
    else $error("enumeration still running after count write");

  // one request at a time through the sequencer
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request taken while sequencer busy");

endmodule

@@ bench/swap_recursive_permutation_generator_top_tb.sv @@
// ----------------------------------------------------------------------------
// swap_recursive_permutation_generator_top_tb
// checks every result against an in-bench model of the swap-and-restore
// enumeration, over directed corner cases, random restart/next traffic under
// several idle patterns, a long output stall and element_count rewrites
// ----------------------------------------------------------------------------
module swap_recursive_permutation_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [spg_pkg::CFG_ADDR_W-1:0] COUNT_ADDR =
    {spg_pkg::REG_ELEMENT_COUNT, 2'b00};

  typedef struct packed {
    logic [spg_pkg::ORDER_W-1:0] order_word;
    logic [spg_pkg::SEQ_W-1:0]   sequence_number;
    logic                        is_last;
    logic                        exhausted;
  } perm_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [spg_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [spg_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [spg_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  spg_in_if  in_ch ();
  spg_out_if out_ch ();

  swap_recursive_permutation_generator_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // model state
  logic [spg_pkg::ELEM_W-1:0]  perm_q  [spg_pkg::MAX_ELEMS];
  logic [spg_pkg::ELEM_W-1:0]  level_q [spg_pkg::MAX_ELEMS];
  logic [spg_pkg::SEQ_W-1:0]   seq_q;
  bit                          running_q;
  logic [spg_pkg::COUNT_W-1:0] count_reg;

  perm_result_t expected_perms [$];
  int unsigned  fail_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_left;
  int unsigned  cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic int unsigned active_count();
    int unsigned n;
    n = 32'(count_reg);
    if (n == 0) n = 1;
    if (n > spg_pkg::MAX_ELEMS) n = spg_pkg::MAX_ELEMS;
    return n;
  endfunction

  function automatic void reset_order();
    for (int k = 0; k < spg_pkg::MAX_ELEMS; k++) begin
      perm_q[k]  = spg_pkg::ELEM_W'(k);
      level_q[k] = spg_pkg::ELEM_W'(k);
    end
  endfunction

  function automatic void swap_positions(int unsigned a, int unsigned b);
    logic [spg_pkg::ELEM_W-1:0] t;
    if (a >= spg_pkg::MAX_ELEMS || b >= spg_pkg::MAX_ELEMS) return;
    t         = perm_q[a];
    perm_q[a] = perm_q[b];
    perm_q[b] = t;
  endfunction

  // unwind levels until one can take its next choice
  function automatic bit step_leaf(int unsigned n);
    int unsigned i;
    if (n < 2) return 1'b0;
    i = n - 1;
    while (i > 0) begin
      i--;
      swap_positions(i, 32'(level_q[i]));
      if (32'(level_q[i]) < n - 1) begin
        level_q[i] = level_q[i] + spg_pkg::ELEM_W'(1);
        swap_positions(i, 32'(level_q[i]));
        for (int unsigned k = i + 1; k < spg_pkg::MAX_ELEMS; k++) begin
          level_q[k] = spg_pkg::ELEM_W'(k);
        end
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit final_leaf(int unsigned n);
    for (int unsigned k = 0; k + 1 < n; k++) begin
      if (level_q[k] != spg_pkg::ELEM_W'(n - 1)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic perm_result_t predict_perm(bit restart);
    perm_result_t r;
    int unsigned  n;
    bit           ok;
    n = active_count();
    r = '0;
    if (restart) begin
      reset_order();
      seq_q     = spg_pkg::SEQ_W'(1);
      running_q = 1'b1;
      ok        = 1'b1;
    end else if (running_q) begin
      ok = step_leaf(n);
      if (ok) begin
        seq_q = seq_q + spg_pkg::SEQ_W'(1);
      end else begin
        reset_order();
        running_q = 1'b0;
        seq_q     = '0;
      end
    end else begin
      ok = 1'b0;
    end
    if (!ok) begin
      r.exhausted = 1'b1;
      return r;
    end
    for (int k = 0; k < n && k < spg_pkg::OUT_POS; k++) begin
      r.order_word[spg_pkg::ELEM_W*k +: spg_pkg::ELEM_W] = perm_q[k];
    end
    r.sequence_number = seq_q;
    r.is_last         = final_leaf(n);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    perm_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_perms.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_ch.order_word), 64'(0));
      end else begin
        want = expected_perms.pop_front();
        if (out_ch.order_word !== want.order_word)
          report_mismatch("order_word", 64'(out_ch.order_word), 64'(want.order_word));
        if (out_ch.sequence_number !== want.sequence_number)
          report_mismatch("sequence_number", 64'(out_ch.sequence_number),
                          64'(want.sequence_number));
        if (out_ch.is_last !== want.is_last)
          report_mismatch("is_last", 64'(out_ch.is_last), 64'(want.is_last));
        if (out_ch.exhausted !== want.exhausted)
          report_mismatch("exhausted", 64'(out_ch.exhausted), 64'(want.exhausted));
      end
    end
  end

  // result ready, with long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(bit restart);
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_perms.push_back(predict_perm(restart));
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.restart <= 1'($urandom_range(1));
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_perms.size() != 0) @(posedge clk);
  endtask

  task automatic write_count(logic [spg_pkg::COUNT_W-1:0] value);
    drain_results();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= COUNT_ADDR;
    cfg_pwdata  <= spg_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    count_reg = value;
    running_q = 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== spg_pkg::CFG_DATA_W'(count_reg))
      report_mismatch("element_count readback", 64'(cfg_prdata), 64'(count_reg));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [spg_pkg::COUNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 15) return spg_pkg::COUNT_W'($urandom_range(2, 1));
    if (r < 70) return spg_pkg::COUNT_W'($urandom_range(5, 3));
    if (r < 85) return spg_pkg::COUNT_W'(6);
    return spg_pkg::COUNT_W'($urandom_range(15, 7));
  endfunction

  task automatic test_before_start();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
  endtask

  task automatic test_single_element();
    write_count(spg_pkg::COUNT_W'(1));
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    write_count(spg_pkg::COUNT_W'(0));
    send_request(1'b1);
    send_request(1'b0);
  endtask

  task automatic test_short_enumerations();
    write_count(spg_pkg::COUNT_W'(2));
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    write_count(spg_pkg::COUNT_W'(3));
    send_request(1'b1);
    repeat (6) send_request(1'b0);
  endtask

  task automatic test_count_change();
    write_count(spg_pkg::COUNT_W'(15));
    send_request(1'b1);
    send_request(1'b0);
    write_count(spg_pkg::COUNT_W'(4));
    send_request(1'b0);
    send_request(1'b1);
  endtask

  task automatic test_random_traffic(int unsigned items);
    int unsigned sent;
    int unsigned set_len;
    sent = 0;
    while (sent < items) begin
      write_count(pick_count());
      set_len = $urandom_range(120, 20);
      if ($urandom_range(9) == 0) begin
        send_request(1'b0);
        sent++;
      end
      for (int unsigned j = 0; j < set_len && sent < items; j++) begin
        if (!running_q) send_request($urandom_range(99) < 85);
        else send_request($urandom_range(99) < 3);
        sent++;
      end
    end
  endtask

  task automatic test_output_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_count(spg_pkg::COUNT_W'(3));
    hold_left = 400;
    send_request(1'b1);
    repeat (15) send_request(1'b0);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.restart  = 1'b0;
    out_ch.ready   = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    reset_order();
    seq_q          = '0;
    running_q      = 1'b0;
    count_reg      = spg_pkg::COUNT_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_start();
    test_single_element();
    test_short_enumerations();
    test_count_change();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(340);
    send_idle_pct  = 65;
    recv_stall_pct = 0;
    test_random_traffic(340);
    send_idle_pct  = 0;
    recv_stall_pct = 65;
    test_random_traffic(340);
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    test_random_traffic(340);

    test_output_stall();

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/spg_pkg.sv
sv/spg_ifs.sv
sv/spg_swap_unit.sv
sv/spg_apb_regs.sv
sv/swap_recursive_permutation_generator_top.sv
bench/swap_recursive_permutation_generator_top_tb.sv
